// ===== design/complex_column_phase_rotator_assert.svh =====
// ----------------------------------------------------------------------------
// Assertion macros for the column phase rotator checker
// ----------------------------------------------------------------------------
`ifndef COMPLEX_COLUMN_PHASE_ROTATOR_ASSERT_SVH
`define COMPLEX_COLUMN_PHASE_ROTATOR_ASSERT_SVH

// Same-cycle implication, disabled while reset is asserted.
`define CCPR_ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("ccpr: same-cycle check failed");

// Next-cycle implication, disabled while reset is asserted.
`define CCPR_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("ccpr: next-cycle check failed");

`endif

// ===== design/ccpr_pkg.sv =====
// ----------------------------------------------------------------------------
// ccpr_pkg
// Shared constants, codes and types of the column phase rotator.
// ----------------------------------------------------------------------------
`default_nettype none

package ccpr_pkg;

    // CORDIC geometry
    localparam int CORDIC_STEPS = 24;
    localparam int GUARD_BITS   = 4;
    localparam int GROWTH_BITS  = 3;
    localparam int TURN_WIDTH   = 32;
    localparam int Z_WIDTH      = 33;

    // Gain correction: 0.60725... scaled by 2^24, with a zero sign bit
    localparam int GAIN_WIDTH = 25;
    localparam logic [GAIN_WIDTH-1:0] GAIN_FIX = 25'd10188014;
    localparam int OUT_SHIFT = 28;

    // Result queue depth, also the limit of outstanding rotate transactions
    localparam int FIFO_DEPTH = 32;

    // Configuration register indexes
    localparam int CFG_INDEX_WIDTH = 2;
    localparam logic [CFG_INDEX_WIDTH-1:0] REG_DIRECTION    = 2'd0;
    localparam logic [CFG_INDEX_WIDTH-1:0] REG_COLUMN_COUNT = 2'd1;

    // Input action codes
    localparam logic ACTION_LOAD   = 1'b0;
    localparam logic ACTION_ROTATE = 1'b1;

    // Arctangent of 2^-i in units of 2^-32 turn
    localparam logic [TURN_WIDTH-1:0] ATAN_TURNS [CORDIC_STEPS] = '{
        32'd536870912, 32'd316933406, 32'd167458907, 32'd85004756,
        32'd42667331,  32'd21354465,  32'd10679838,  32'd5340245,
        32'd2670163,   32'd1335087,   32'd667544,    32'd333772,
        32'd166886,    32'd83443,     32'd41722,     32'd20861,
        32'd10430,     32'd5215,      32'd2608,      32'd1304,
        32'd652,       32'd326,       32'd163,       32'd81
    };

    // Sideband that travels with each sample through the pipeline
    typedef struct packed {
        logic valid;
        logic column_error;
        logic row_end;
    } ccpr_tag_t;

endpackage

`default_nettype wire

// ===== design/ccpr_rotator.sv =====
// ----------------------------------------------------------------------------
// ccpr_rotator
// Pipelined quadrant pre-rotation, 24-step CORDIC, gain correction and
// rounding with saturation. Advances every cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module ccpr_rotator
    import ccpr_pkg::*;
#(
    parameter int SAMPLE_WIDTH = 16,
    parameter int ANGLE_WIDTH  = 16
)(
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           direction_negative,
    input  logic        [ANGLE_WIDTH-1:0]  angle,
    input  logic signed [SAMPLE_WIDTH-1:0] sample_real,
    input  logic signed [SAMPLE_WIDTH-1:0] sample_imag,
    input  ccpr_tag_t                      tag_in,
    output logic signed [SAMPLE_WIDTH-1:0] rotated_real,
    output logic signed [SAMPLE_WIDTH-1:0] rotated_imag,
    output ccpr_tag_t                      tag_out
);

    localparam int XW = SAMPLE_WIDTH + GUARD_BITS + GROWTH_BITS;
    localparam int PW = XW + GAIN_WIDTH;
    localparam logic signed [PW-1:0] ROUND_HALF = PW'(1) <<< (OUT_SHIFT - 1);
    localparam logic signed [PW-1:0] SAT_HI =
        {{(PW - SAMPLE_WIDTH + 1){1'b0}}, {(SAMPLE_WIDTH - 1){1'b1}}};
    localparam logic signed [PW-1:0] SAT_LO = ~SAT_HI;

    // pre-rotation
    logic [TURN_WIDTH-1:0]   turn_aligned;
    logic [TURN_WIDTH-1:0]   turn_signed;
    logic signed [XW-1:0]    re_ext;
    logic signed [XW-1:0]    im_ext;
    logic signed [XW-1:0]    pre_x;
    logic signed [XW-1:0]    pre_y;
    logic signed [Z_WIDTH-1:0] pre_z;

    // CORDIC stages
    logic signed [XW-1:0]      x_reg [0:CORDIC_STEPS];
    logic signed [XW-1:0]      y_reg [0:CORDIC_STEPS];
    logic signed [Z_WIDTH-1:0] z_reg [0:CORDIC_STEPS];
    ccpr_tag_t                 tag_reg [0:CORDIC_STEPS];
    logic signed [XW-1:0]      x_next [0:CORDIC_STEPS-1];
    logic signed [XW-1:0]      y_next [0:CORDIC_STEPS-1];
    logic signed [Z_WIDTH-1:0] z_next [0:CORDIC_STEPS-1];

    // gain and rounding
    logic signed [PW-1:0]           prod_x_reg;
    logic signed [PW-1:0]           prod_y_reg;
    ccpr_tag_t                      prod_tag_reg;
    logic signed [PW-1:0]           round_x;
    logic signed [PW-1:0]           round_y;
    logic signed [SAMPLE_WIDTH-1:0] sat_x;
    logic signed [SAMPLE_WIDTH-1:0] sat_y;
    logic signed [SAMPLE_WIDTH-1:0] out_real_reg;
    logic signed [SAMPLE_WIDTH-1:0] out_imag_reg;
    ccpr_tag_t                      out_tag_reg;

    assign turn_aligned = TURN_WIDTH'(angle) << (TURN_WIDTH - ANGLE_WIDTH);
    assign turn_signed  = direction_negative ? (~turn_aligned + 1'b1) : turn_aligned;
    assign re_ext = XW'(sample_real) <<< GUARD_BITS;
    assign im_ext = XW'(sample_imag) <<< GUARD_BITS;
    assign pre_z  = {{(Z_WIDTH - TURN_WIDTH + 2){1'b0}}, turn_signed[TURN_WIDTH-3:0]};

    // rotate by a multiple of 90 degrees picked by the top two angle bits
    always_comb
    begin
        case (turn_signed[TURN_WIDTH-1:TURN_WIDTH-2])
            2'd1:
            begin
                pre_x = -im_ext;
                pre_y = re_ext;
            end
            2'd2:
            begin
                pre_x = -re_ext;
                pre_y = -im_ext;
            end
            2'd3:
            begin
                pre_x = im_ext;
                pre_y = -re_ext;
            end
            default:
            begin
                pre_x = re_ext;
                pre_y = im_ext;
            end
        endcase
    end

    // one micro-rotation per stage
    always_comb
    begin
        for (int i = 0; i < CORDIC_STEPS; i++)
        begin
            if (!z_reg[i][Z_WIDTH-1])
            begin
                x_next[i] = x_reg[i] - (y_reg[i] >>> i);
                y_next[i] = y_reg[i] + (x_reg[i] >>> i);
                z_next[i] = z_reg[i] - $signed(Z_WIDTH'(ATAN_TURNS[i]));
            end
            else
            begin
                x_next[i] = x_reg[i] + (y_reg[i] >>> i);
                y_next[i] = y_reg[i] - (x_reg[i] >>> i);
                z_next[i] = z_reg[i] + $signed(Z_WIDTH'(ATAN_TURNS[i]));
            end
        end
    end

    always_ff @(posedge clk)
    begin
        x_reg[0] <= pre_x;
        y_reg[0] <= pre_y;
        z_reg[0] <= pre_z;
        for (int i = 0; i < CORDIC_STEPS; i++)
        begin
            x_reg[i+1] <= x_next[i];
            y_reg[i+1] <= y_next[i];
            z_reg[i+1] <= z_next[i];
        end
        prod_x_reg   <= x_reg[CORDIC_STEPS] * $signed(GAIN_FIX);
        prod_y_reg   <= y_reg[CORDIC_STEPS] * $signed(GAIN_FIX);
        out_real_reg <= prod_tag_reg.column_error ? '0 : sat_x;
        out_imag_reg <= prod_tag_reg.column_error ? '0 : sat_y;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i <= CORDIC_STEPS; i++)
            begin
                tag_reg[i] <= '0;
            end
            prod_tag_reg <= '0;
            out_tag_reg  <= '0;
        end
        else
        begin
            tag_reg[0] <= tag_in;
            for (int i = 0; i < CORDIC_STEPS; i++)
            begin
                tag_reg[i+1] <= tag_reg[i];
            end
            prod_tag_reg <= tag_reg[CORDIC_STEPS];
            out_tag_reg  <= prod_tag_reg;
        end
    end

    // round half up, then clamp to the sample range
    assign round_x = (prod_x_reg + ROUND_HALF) >>> OUT_SHIFT;
    assign round_y = (prod_y_reg + ROUND_HALF) >>> OUT_SHIFT;

    always_comb
    begin
        if (round_x > SAT_HI)
            sat_x = SAT_HI[SAMPLE_WIDTH-1:0];
        else if (round_x < SAT_LO)
            sat_x = SAT_LO[SAMPLE_WIDTH-1:0];
        else
            sat_x = round_x[SAMPLE_WIDTH-1:0];

        if (round_y > SAT_HI)
            sat_y = SAT_HI[SAMPLE_WIDTH-1:0];
        else if (round_y < SAT_LO)
            sat_y = SAT_LO[SAMPLE_WIDTH-1:0];
        else
            sat_y = round_y[SAMPLE_WIDTH-1:0];
    end

    assign rotated_real = out_real_reg;
    assign rotated_imag = out_imag_reg;
    assign tag_out      = out_tag_reg;

endmodule

`default_nettype wire

// ===== design/complex_column_phase_rotator.sv =====
// ----------------------------------------------------------------------------
// complex_column_phase_rotator
// Rotates complex samples by a per-column phase taken from a loadable table.
// ----------------------------------------------------------------------------
// One transaction is taken per cycle while in_stall is low, loads and samples
// alike. A sample's result passes through the input registers, the rotation
// pipeline and the result queue before it reaches the output. A load writes
// one phase table entry and returns nothing; a sample returns its rotated
// value, the row end mark and the column error flag. The rotation pipeline
// never stops: results land in a 32-entry result queue, and in_stall rises
// only while 32 rotate transactions are outstanding (in the pipeline or
// waiting in the queue), so a steady out_stall throttles the input after the
// queue fills. Table entries that were never loaded read back undefined.
// Write the configuration registers only while no transaction is in flight.
// ----------------------------------------------------------------------------
`default_nettype none

module complex_column_phase_rotator
    import ccpr_pkg::*;
#(
    parameter int MAX_COLUMNS  = 1024,
    parameter int SAMPLE_WIDTH = 16,
    parameter int ANGLE_WIDTH  = 16
)(
    input  logic                              clk,
    input  logic                              rst_n,

    // configuration write port
    input  logic                              cfg_write_enable,
    input  logic [CFG_INDEX_WIDTH-1:0]        cfg_index,
    input  logic [$clog2(MAX_COLUMNS):0]      cfg_data,

    // input channel
    input  logic                              in_valid,
    output logic                              in_stall,
    input  logic                              action,
    input  logic [$clog2(MAX_COLUMNS)-1:0]    column_index,
    input  logic [ANGLE_WIDTH-1:0]            phase_angle,
    input  logic signed [SAMPLE_WIDTH-1:0]    sample_real,
    input  logic signed [SAMPLE_WIDTH-1:0]    sample_imag,

    // output channel
    output logic                              out_valid,
    input  logic                              out_stall,
    output logic signed [SAMPLE_WIDTH-1:0]    rotated_real,
    output logic signed [SAMPLE_WIDTH-1:0]    rotated_imag,
    output logic                              row_end,
    output logic                              column_error
);

    localparam int IDX_W    = $clog2(MAX_COLUMNS);
    localparam int CNT_W    = IDX_W + 1;
    localparam int PTR_W    = $clog2(FIFO_DEPTH);
    localparam int CREDIT_W = $clog2(FIFO_DEPTH + 1);

    typedef struct packed {
        logic signed [SAMPLE_WIDTH-1:0] re;
        logic signed [SAMPLE_WIDTH-1:0] im;
        logic                           row_end;
        logic                           column_error;
    } result_t;

    // configuration registers
    logic             direction_negative_reg;
    logic [CNT_W-1:0] column_count_reg;

    // input decode
    logic             in_accept;
    logic             sample_accept;
    logic [CNT_W-1:0] column_ext;
    logic             column_in_table;
    logic             column_bad;
    logic             column_last;

    // phase table and first stage
    logic [ANGLE_WIDTH-1:0]         phase_mem [MAX_COLUMNS];
    logic [ANGLE_WIDTH-1:0]         angle_rd_reg;
    logic signed [SAMPLE_WIDTH-1:0] s0_real_reg;
    logic signed [SAMPLE_WIDTH-1:0] s0_imag_reg;
    ccpr_tag_t                      s0_tag_reg;
    ccpr_tag_t                      s0_tag_next;

    // rotator results
    logic signed [SAMPLE_WIDTH-1:0] rot_real;
    logic signed [SAMPLE_WIDTH-1:0] rot_imag;
    ccpr_tag_t                      rot_tag;

    // result queue and credit count
    result_t             fifo_mem [FIFO_DEPTH];
    logic [PTR_W-1:0]    wr_ptr_reg;
    logic [PTR_W-1:0]    rd_ptr_reg;
    logic [CREDIT_W-1:0] fifo_count_reg;
    logic [CREDIT_W-1:0] fifo_count_next;
    logic [CREDIT_W-1:0] credit_reg;
    logic [CREDIT_W-1:0] credit_next;
    logic                out_accept;
    result_t             head;

    // ------------------------------------------------------------------
    // Configuration: ignore unknown indexes
    // ------------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            direction_negative_reg <= 1'b0;
            column_count_reg       <= CNT_W'(MAX_COLUMNS);
        end
        else if (cfg_write_enable)
        begin
            unique case (cfg_index)
                REG_DIRECTION:    direction_negative_reg <= cfg_data[0];
                REG_COLUMN_COUNT: column_count_reg       <= cfg_data;
                default:          ;
            endcase
        end
    end

    // ------------------------------------------------------------------
    // Input side: stall only when every queue slot is already promised
    // ------------------------------------------------------------------
    assign in_stall      = (credit_reg == CREDIT_W'(FIFO_DEPTH));
    assign in_accept     = in_valid && !in_stall;
    assign sample_accept = in_accept && (action == ACTION_ROTATE);

    assign column_ext      = {1'b0, column_index};
    assign column_in_table = (column_ext < CNT_W'(MAX_COLUMNS));
    assign column_bad      = !column_in_table || (column_ext >= column_count_reg);
    assign column_last     = ((column_ext + CNT_W'(1)) == column_count_reg);

    always_comb
    begin
        s0_tag_next.valid        = sample_accept;
        s0_tag_next.column_error = column_bad;
        s0_tag_next.row_end      = column_last && !column_bad;
    end

    // Write the table on a load, read it on a sample; a load is visible to
    // the next transaction, whose read happens at a later edge than the write.
    always_ff @(posedge clk)
    begin
        if (in_accept && (action == ACTION_LOAD) && column_in_table)
        begin
            phase_mem[column_index] <= phase_angle;
        end
        if (sample_accept && column_in_table)
        begin
            angle_rd_reg <= phase_mem[column_index];
        end
        if (sample_accept)
        begin
            s0_real_reg <= sample_real;
            s0_imag_reg <= sample_imag;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s0_tag_reg <= '0;
        end
        else
        begin
            s0_tag_reg <= s0_tag_next;
        end
    end

    // ------------------------------------------------------------------
    // Rotation pipeline
    // ------------------------------------------------------------------
    ccpr_rotator #(
        .SAMPLE_WIDTH (SAMPLE_WIDTH),
        .ANGLE_WIDTH  (ANGLE_WIDTH)
    ) u_rotator (
        .clk                (clk),
        .rst_n              (rst_n),
        .direction_negative (direction_negative_reg),
        .angle              (angle_rd_reg),
        .sample_real        (s0_real_reg),
        .sample_imag        (s0_imag_reg),
        .tag_in             (s0_tag_reg),
        .rotated_real       (rot_real),
        .rotated_imag       (rot_imag),
        .tag_out            (rot_tag)
    );

    // ------------------------------------------------------------------
    // Result queue: push every finished sample, pop on output transaction
    // ------------------------------------------------------------------
    assign out_valid  = (fifo_count_reg != '0);
    assign out_accept = out_valid && !out_stall;
    assign head       = fifo_mem[rd_ptr_reg];

    always_ff @(posedge clk)
    begin
        if (rot_tag.valid)
        begin
            fifo_mem[wr_ptr_reg] <= '{re:           rot_real,
                                      im:           rot_imag,
                                      row_end:      rot_tag.row_end,
                                      column_error: rot_tag.column_error};
        end
    end

    always_comb
    begin
        fifo_count_next = fifo_count_reg;
        if (rot_tag.valid && !out_accept)
            fifo_count_next = fifo_count_reg + 1'b1;
        else if (!rot_tag.valid && out_accept)
            fifo_count_next = fifo_count_reg - 1'b1;

        credit_next = credit_reg;
        if (sample_accept && !out_accept)
            credit_next = credit_reg + 1'b1;
        else if (!sample_accept && out_accept)
            credit_next = credit_reg - 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg     <= '0;
            rd_ptr_reg     <= '0;
            fifo_count_reg <= '0;
            credit_reg     <= '0;
        end
        else
        begin
            if (rot_tag.valid)
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            if (out_accept)
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            fifo_count_reg <= fifo_count_next;
            credit_reg     <= credit_next;
        end
    end

    assign rotated_real = head.re;
    assign rotated_imag = head.im;
    assign row_end      = head.row_end;
    assign column_error = head.column_error;

endmodule

`default_nettype wire

// ===== design/ccpr_checker.sv =====
// ----------------------------------------------------------------------------
// ccpr_checker
// Port-level checks of the column phase rotator, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

`include "complex_column_phase_rotator_assert.svh"

module ccpr_checker #(
    parameter int SAMPLE_WIDTH = 16
)(
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire logic                           in_stall,
    input  wire logic                           out_valid,
    input  wire logic                           out_stall,
    input  wire logic signed [SAMPLE_WIDTH-1:0] rotated_real,
    input  wire logic signed [SAMPLE_WIDTH-1:0] rotated_imag,
    input  wire logic                           row_end,
    input  wire logic                           column_error
);

    // an errored column returns a zero sample and never closes a row
    `CCPR_ASSERT_IMPLY(a_error_result_zero, clk, rst_n, out_valid && column_error, rotated_real == '0 && rotated_imag == '0 && !row_end)

    // a full credit count means results are already waiting in the queue
    `CCPR_ASSERT_IMPLY(a_stall_needs_backlog, clk, rst_n, in_stall, out_valid)

    // a stalled result holds
    `CCPR_ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && out_stall, out_valid && $stable(rotated_real) && $stable(rotated_imag) && $stable(row_end) && $stable(column_error))

endmodule

bind complex_column_phase_rotator ccpr_checker #(
    .SAMPLE_WIDTH (SAMPLE_WIDTH)
) u_ccpr_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_stall     (in_stall),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .rotated_real (rotated_real),
    .rotated_imag (rotated_imag),
    .row_end      (row_end),
    .column_error (column_error)
);

`default_nettype wire

// ===== tb/complex_column_phase_rotator_tb.sv =====
// ----------------------------------------------------------------------------
// complex_column_phase_rotator_tb
// Self-checking bench for the column phase rotator. Load both ends of the
// phase table, run directed extremes and column bound cases, then random row
// streams under several register settings with random idling on both
// channels and one long receiver hold-off. Each rotate transaction is
// predicted by a local CORDIC model and compared field by field with the
// block's result, in order.
// ----------------------------------------------------------------------------
`default_nettype none

module complex_column_phase_rotator_tb;
    import ccpr_pkg::*;

    localparam int COLS = 1024;
    localparam int CW   = $clog2(COLS);
    localparam int SW   = 16;
    localparam int AW   = 16;

    localparam longint SAMPLE_MAX = (longint'(1) <<< (SW - 1)) - 1;
    localparam longint SAMPLE_MIN = -SAMPLE_MAX - 1;

    // Quiet time before a register write, well past the rotation pipeline's depth.
    localparam int SETTLE_CYCLES   = 40;
    localparam int HOLD_OFF_CYCLES = 300;
    localparam int WATCHDOG_LIMIT  = 3000;
    localparam int RANDOM_PHASES   = 10;
    localparam int PHASE_ITEMS     = 78;
    // Columns loaded at each end of the table before any sample
    localparam int FILL_SPAN       = 128;

    // Register indexes with no register behind them
    localparam logic [CFG_INDEX_WIDTH-1:0] REG_UNUSED_LOW  = 2'd2;
    localparam logic [CFG_INDEX_WIDTH-1:0] REG_UNUSED_HIGH = 2'd3;

    typedef struct packed {
        logic signed [SW-1:0] rotated_real;
        logic signed [SW-1:0] rotated_imag;
        logic                 row_end;
        logic                 column_error;
    } rotation_result_t;

    logic                 clk;
    logic                 rst_n;
    logic                 cfg_write_enable;
    logic [CFG_INDEX_WIDTH-1:0] cfg_index;
    logic [CW:0]          cfg_data;
    logic                 in_valid;
    logic                 in_stall;
    logic                 action;
    logic [CW-1:0]        column_index;
    logic [AW-1:0]        phase_angle;
    logic signed [SW-1:0] sample_real;
    logic signed [SW-1:0] sample_imag;
    logic                 out_valid;
    logic                 out_stall;
    logic signed [SW-1:0] rotated_real;
    logic signed [SW-1:0] rotated_imag;
    logic                 row_end;
    logic                 column_error;

    // Local copy of the block's state, updated as transactions are accepted
    logic [AW-1:0]        phase_copy [COLS];
    bit                   phase_written [COLS];
    logic                 direction_copy;
    logic [CW:0]          column_count_copy;

    rotation_result_t     pending_rotations [$];

    bit                   sender_steady;
    bit                   receiver_steady;
    bit                   hold_off_request;
    int                   mismatch_count;
    int                   samples_sent;
    int                   loads_sent;
    int                   results_checked;
    int                   settings_applied;
    int                   idle_cycles;

    complex_column_phase_rotator u_top (
        .clk              (clk),
        .rst_n            (rst_n),
        .cfg_write_enable (cfg_write_enable),
        .cfg_index        (cfg_index),
        .cfg_data         (cfg_data),
        .in_valid         (in_valid),
        .in_stall         (in_stall),
        .action           (action),
        .column_index     (column_index),
        .phase_angle      (phase_angle),
        .sample_real      (sample_real),
        .sample_imag      (sample_imag),
        .out_valid        (out_valid),
        .out_stall        (out_stall),
        .rotated_real     (rotated_real),
        .rotated_imag     (rotated_imag),
        .row_end          (row_end),
        .column_error     (column_error)
    );

    initial
    begin
        clk = 1'b0;
    end

    always #6 clk = ~clk;

    // ------------------------------------------------------------------
    // Prediction
    // ------------------------------------------------------------------

    // Apply the gain correction, round half upward, saturate to sample range.
    function automatic logic signed [SW-1:0] gain_round_saturate(input longint v);
        longint r;
        r = (v * longint'(GAIN_FIX) + (longint'(1) <<< (OUT_SHIFT - 1))) >>> OUT_SHIFT;
        if (r > SAMPLE_MAX)
            r = SAMPLE_MAX;
        else if (r < SAMPLE_MIN)
            r = SAMPLE_MIN;
        return r[SW-1:0];
    endfunction

    function automatic rotation_result_t rotate_by_column(
        input logic [CW-1:0]        col,
        input logic signed [SW-1:0] re,
        input logic signed [SW-1:0] im
    );
        rotation_result_t     res;
        logic [TURN_WIDTH-1:0] turn;
        longint               x;
        longint               y;
        longint               z;
        longint               t;
        longint               dx;
        longint               dy;

        res = '0;
        if ({1'b0, col} >= column_count_copy)
        begin
            // out-of-range column: zero sample with the error flag
            res.column_error = 1'b1;
            return res;
        end

        turn = {phase_copy[col], {(TURN_WIDTH - AW){1'b0}}};
        if (direction_copy)
            turn = ~turn + 1'b1;
        z = longint'(turn[TURN_WIDTH-3:0]);
        x = longint'(re) * (longint'(1) <<< GUARD_BITS);
        y = longint'(im) * (longint'(1) <<< GUARD_BITS);

        // quadrant pre-rotation from the top two turn bits
        case (turn[TURN_WIDTH-1:TURN_WIDTH-2])
            2'd1:
            begin
                t = x;
                x = -y;
                y = t;
            end
            2'd2:
            begin
                x = -x;
                y = -y;
            end
            2'd3:
            begin
                t = x;
                x = y;
                y = -t;
            end
            default:
            begin
            end
        endcase

        for (int i = 0; i < CORDIC_STEPS; i++)
        begin
            dx = y >>> i;
            dy = x >>> i;
            if (z >= 0)
            begin
                x = x - dx;
                y = y + dy;
                z = z - longint'(ATAN_TURNS[i]);
            end
            else
            begin
                x = x + dx;
                y = y - dy;
                z = z + longint'(ATAN_TURNS[i]);
            end
        end

        res.rotated_real = gain_round_saturate(x);
        res.rotated_imag = gain_round_saturate(y);
        res.row_end      = ({1'b0, col} + 1'b1 == column_count_copy);
        return res;
    endfunction

    // A sample may use a column that is out of range or already loaded.
    function automatic bit column_usable(input logic [CW-1:0] col);
        return ({1'b0, col} >= column_count_copy) || phase_written[col];
    endfunction

    // ------------------------------------------------------------------
    // Random choices
    // ------------------------------------------------------------------

    // Mostly back-to-back, some short gaps, a few long ones.
    function automatic int pick_gap(input bit steady);
        int r;
        if (steady)
            return 0;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        if (r < 92)
            return $urandom_range(1, 3);
        return $urandom_range(10, 60);
    endfunction

    function automatic logic signed [SW-1:0] pick_part();
        case ($urandom_range(0, 9))
            0:       return SAMPLE_MAX[SW-1:0];
            1:       return SAMPLE_MIN[SW-1:0];
            2:       return '0;
            3:       return '1;
            default: return SW'($urandom());
        endcase
    endfunction

    function automatic logic [AW-1:0] pick_angle();
        case ($urandom_range(0, 11))
            0:       return 16'h0000;
            1:       return 16'h4000;
            2:       return 16'h8000;
            3:       return 16'hC000;
            4:       return 16'hFFFF;
            default: return AW'($urandom());
        endcase
    endfunction

    // Random column that a sample may use; column 0 is always loaded.
    function automatic logic [CW-1:0] pick_sample_column();
        logic [CW-1:0] c;
        c = CW'($urandom());
        for (int t = 0; t < 32 && !column_usable(c); t++)
            c = CW'($urandom());
        if (!column_usable(c))
            c = '0;
        return c;
    endfunction

    // ------------------------------------------------------------------
    // Sender and register access
    // ------------------------------------------------------------------

    // Offer one transaction and hold it until accepted; leave valid high so
    // a following transaction may go out back-to-back.
    task automatic send_item(
        input logic                 act,
        input logic [CW-1:0]        col,
        input logic [AW-1:0]        ang,
        input logic signed [SW-1:0] re,
        input logic signed [SW-1:0] im
    );
        int gap;
        gap = pick_gap(sender_steady);
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid     <= 1'b1;
        action       <= act;
        column_index <= col;
        phase_angle  <= ang;
        sample_real  <= re;
        sample_imag  <= im;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);

        if (act == ACTION_LOAD)
        begin
            phase_copy[col]    = ang;
            phase_written[col] = 1'b1;
            loads_sent++;
        end
        else
        begin
            pending_rotations.push_back(rotate_by_column(col, re, im));
            samples_sent++;
        end
    endtask

    task automatic send_sample(
        input logic [CW-1:0]        col,
        input logic signed [SW-1:0] re,
        input logic signed [SW-1:0] im
    );
        send_item(ACTION_ROTATE, col, AW'($urandom()), re, im);
    endtask

    // Drop valid, wait for every result, then let the block sit quiet.
    task automatic wait_for_idle();
        in_valid <= 1'b0;
        @(posedge clk);
        while (pending_rotations.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_register(input logic [CFG_INDEX_WIDTH-1:0] idx,
                                  input logic [CW:0] value);
        cfg_write_enable <= 1'b1;
        cfg_index        <= idx;
        cfg_data         <= value;
        @(posedge clk);
        if (idx == REG_DIRECTION)
            direction_copy = value[0];
        else if (idx == REG_COLUMN_COUNT)
            column_count_copy = value;
        cfg_write_enable <= 1'b0;
        @(posedge clk);
    endtask

    task automatic apply_settings(input logic dir, input logic [CW:0] count);
        wait_for_idle();
        write_register(REG_DIRECTION, {{CW{1'b0}}, dir});
        write_register(REG_COLUMN_COUNT, count);
        settings_applied++;
    endtask

    // ------------------------------------------------------------------
    // Receiver: random stall pattern, or one long hold-off on request
    // ------------------------------------------------------------------
    initial
    begin
        int n;
        out_stall = 1'b0;
        @(posedge clk);
        forever
        begin
            if (hold_off_request)
            begin
                hold_off_request = 1'b0;
                out_stall <= 1'b1;
                repeat (HOLD_OFF_CYCLES) @(posedge clk);
                out_stall <= 1'b0;
                @(posedge clk);
            end
            else
            begin
                n = pick_gap(receiver_steady);
                if (n > 0)
                begin
                    out_stall <= 1'b1;
                    repeat (n) @(posedge clk);
                end
                out_stall <= 1'b0;
                repeat ($urandom_range(1, 6)) @(posedge clk);
            end
        end
    end

    // ------------------------------------------------------------------
    // Result checking
    // ------------------------------------------------------------------
    task automatic report_mismatch(input string what, input longint got, input longint want);
        mismatch_count++;
        $display("[%0t] mismatch on %s: got %0d, want %0d", $time, what, got, want);
    endtask

    // Compare each accepted result with the oldest prediction.
    always @(posedge clk)
    begin : result_checker
        rotation_result_t want;
        if (rst_n && out_valid === 1'b1 && out_stall === 1'b0)
        begin
            if (pending_rotations.size() == 0)
            begin
                report_mismatch("result with nothing pending", 1, 0);
            end
            else
            begin
                want = pending_rotations.pop_front();
                results_checked++;
                if (rotated_real !== want.rotated_real)
                    report_mismatch("rotated_real", rotated_real, want.rotated_real);
                if (rotated_imag !== want.rotated_imag)
                    report_mismatch("rotated_imag", rotated_imag, want.rotated_imag);
                if (row_end !== want.row_end)
                    report_mismatch("row_end", row_end, want.row_end);
                if (column_error !== want.column_error)
                    report_mismatch("column_error", column_error, want.column_error);
            end
        end
    end

    // Watchdog: end the run if no transaction moves on either channel.
    always @(posedge clk)
    begin
        if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_LIMIT)
        begin
            $display("[%0t] no transaction for %0d cycles", $time, idle_cycles);
            $display("TEST FAILED");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------

    // Load both ends of the table; samples only use loaded columns.
    task automatic fill_phase_table();
        int c;
        for (int k = 0; k < 2 * FILL_SPAN; k++)
        begin
            c = (k < FILL_SPAN) ? k : (COLS - 2 * FILL_SPAN + k);
            sender_steady = (k < FILL_SPAN);
            send_item(ACTION_LOAD, CW'(c), pick_angle(), SW'($urandom()), SW'($urandom()));
        end
        sender_steady = 1'b0;
    endtask

    // Quadrant boundaries and sample extremes, under reset settings first.
    task automatic test_phase_extremes();
        send_sample(CW'(COLS - 1), 16'sh1234, -16'sh0567);  // last column of default row
        send_item(ACTION_LOAD, CW'(0), 16'h0000, '0, '0);
        send_item(ACTION_LOAD, CW'(1), 16'h0001, '0, '0);
        send_item(ACTION_LOAD, CW'(2), 16'h4000, '0, '0);
        send_item(ACTION_LOAD, CW'(3), 16'h8000, '0, '0);
        send_item(ACTION_LOAD, CW'(4), 16'hC000, '0, '0);
        send_item(ACTION_LOAD, CW'(5), 16'hFFFF, '0, '0);
        send_item(ACTION_LOAD, CW'(6), 16'h2000, '0, '0);
        send_sample(CW'(0), SAMPLE_MAX[SW-1:0], SAMPLE_MIN[SW-1:0]);
        send_sample(CW'(1), SAMPLE_MIN[SW-1:0], SAMPLE_MIN[SW-1:0]);
        send_sample(CW'(2), SAMPLE_MAX[SW-1:0], SAMPLE_MAX[SW-1:0]);
        send_sample(CW'(3), SAMPLE_MIN[SW-1:0], SAMPLE_MAX[SW-1:0]);
        send_sample(CW'(4), 16'sd1, -16'sd1);
        send_sample(CW'(5), 16'sd0, 16'sd0);
        send_sample(CW'(6), SAMPLE_MAX[SW-1:0], 16'sd0);
        // negated phase, including the zero and half-turn entries
        apply_settings(1'b1, 11'd1024);
        send_sample(CW'(0), -16'sd1, -16'sd1);
        send_sample(CW'(2), 16'sd12345, -16'sd23456);
        send_sample(CW'(3), SAMPLE_MIN[SW-1:0], 16'sd77);
    endtask

    // Row end, out-of-range columns, count zero, count above table size,
    // and writes to unused register indexes.
    task automatic test_column_bounds();
        apply_settings(1'b0, 11'd8);
        send_sample(CW'(7), 16'sd1000, 16'sd2000);
        send_sample(CW'(8), 16'sd1000, 16'sd2000);
        send_sample(CW'(COLS - 1), SAMPLE_MAX[SW-1:0], SAMPLE_MAX[SW-1:0]);
        apply_settings(1'b0, 11'd0);
        send_sample(CW'(0), 16'sd5, 16'sd5);
        apply_settings(1'b1, 11'd2047);
        send_sample(CW'(COLS - 1), -16'sd300, 16'sd400);
        wait_for_idle();
        write_register(REG_UNUSED_LOW, (CW + 1)'($urandom()));
        write_register(REG_UNUSED_HIGH, (CW + 1)'($urandom()));
        send_sample(CW'(0), 16'sd321, -16'sd654);
    endtask

    // Hold the receiver off for a long stretch while the sender keeps
    // offering, so the result queue fills and the input stalls.
    task automatic test_backpressure();
        apply_settings(1'b0, 11'd64);
        sender_steady    = 1'b1;
        hold_off_request = 1'b1;
        for (int k = 0; k < 96; k++)
            send_sample(CW'(k % 64), pick_part(), pick_part());
        sender_steady = 1'b0;
        // pause until the backlog has drained
        wait_for_idle();
    endtask

    // Row-ordered sample streams with interleaved loads and stray columns.
    task automatic test_random_streams();
        logic [CW:0] count;
        int          row_len;
        int          cursor;
        int          r;
        for (int p = 0; p < RANDOM_PHASES; p++)
        begin
            case (p)
                0:       count = 11'd1024;
                1:       count = 11'd1;
                2:       count = 11'd2;
                3:       count = (CW + 1)'($urandom_range(3, 64));
                4:       count = 11'd0;
                5:       count = 11'd2047;
                6:       count = (CW + 1)'($urandom_range(1000, 1023));
                7:       count = (CW + 1)'($urandom_range(1025, 2046));
                8:       count = (CW + 1)'($urandom_range(1, 1024));
                default: count = 11'd1024;
            endcase
            apply_settings(p[0], count);
            sender_steady   = (p == 3);
            receiver_steady = (p == 3) || (p == 8);
            row_len = (count == 0) ? 1 : ((count > COLS) ? COLS : int'(count));
            cursor  = 0;
            for (int k = 0; k < PHASE_ITEMS; k++)
            begin
                r = $urandom_range(0, 99);
                if (r < 12)
                begin
                    send_item(ACTION_LOAD, CW'($urandom()), pick_angle(),
                              SW'($urandom()), SW'($urandom()));
                end
                else if (r < 25)
                begin
                    send_sample(pick_sample_column(), pick_part(), pick_part());
                end
                else
                begin
                    // jump near the row end now and then so long rows finish
                    if (r < 29 && row_len > 8)
                        cursor = row_len - int'($urandom_range(1, 8));
                    // skip columns that were never loaded
                    while (!column_usable(CW'(cursor)))
                        cursor = (cursor + 1) % row_len;
                    send_sample(CW'(cursor), pick_part(), pick_part());
                    cursor = (cursor + 1) % row_len;
                end
            end
        end
        sender_steady   = 1'b0;
        receiver_steady = 1'b0;
    endtask

    // ------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------
    initial
    begin
        rst_n             = 1'b0;
        cfg_write_enable  = 1'b0;
        cfg_index         = '0;
        cfg_data          = '0;
        in_valid          = 1'b0;
        action            = ACTION_LOAD;
        column_index      = '0;
        phase_angle       = '0;
        sample_real       = '0;
        sample_imag       = '0;
        direction_copy    = 1'b0;
        column_count_copy = 11'd1024;
        sender_steady     = 1'b0;
        receiver_steady   = 1'b0;
        hold_off_request  = 1'b0;
        mismatch_count    = 0;
        samples_sent      = 0;
        loads_sent        = 0;
        results_checked   = 0;
        settings_applied  = 0;

        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        fill_phase_table();
        test_phase_extremes();
        test_column_bounds();
        test_backpressure();
        test_random_streams();

        wait_for_idle();

        if (pending_rotations.size() != 0)
            report_mismatch("results never returned", 0, pending_rotations.size());

        $display("Run covered %0d rotate and %0d load transactions, %0d results checked,",
                 samples_sent, loads_sent, results_checked);
        $display("over %0d register settings with random idling and one long hold-off.",
                 settings_applied);

        if (mismatch_count == 0)
        begin
            $display("TEST PASSED");
        end
        else
        begin
            $display("%0d mismatches", mismatch_count);
            $display("TEST FAILED");
        end
        $finish;
    end

endmodule

`default_nettype wire

// ===== complex_column_phase_rotator.f =====
+incdir+design
design/ccpr_pkg.sv
design/ccpr_rotator.sv
design/complex_column_phase_rotator.sv
design/ccpr_checker.sv
tb/complex_column_phase_rotator_tb.sv
